/* sv/sprite_tile_expander_top_assert.svh */
// Assertion macros for the sprite tile expander top level.
`ifndef SPRITE_TILE_EXPANDER_TOP_ASSERT_SVH
`define SPRITE_TILE_EXPANDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define STE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define STE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STE_ASSERT_ALWAYS(lbl, expr, msg)
`define STE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/ste_pkg.sv */
// Shared types, constants and lookup functions of the sprite tile expander.
`timescale 1ns / 1ps
`default_nettype none
package ste_pkg;

    localparam logic [1:0] CFG_GLOBAL_FLIP = 2'd0;
    localparam logic [1:0] CFG_CROP_LEFT   = 2'd1;
    localparam logic [1:0] CFG_CROP_TOP    = 2'd2;
    localparam logic [1:0] CFG_TILE_MASK   = 2'd3;

    localparam logic [7:0]  ZOOM_MASK      = 8'hfc;
    localparam logic [7:0]  SIZE_MASK      = 8'he0;
    localparam logic [8:0]  ZOOM_ONE       = 9'h100;
    localparam logic [13:0] TILE_MASK_RST  = 14'h3fff;

    typedef struct packed {
        logic [12:0]        base;
        logic signed [11:0] ox;
        logic signed [11:0] oy;
        logic               fx;
        logic               fy;
        logic [8:0]         px;
        logic [8:0]         py;
        logic [1:0]         w_log;
        logic [1:0]         h_log;
        logic [4:0]         dw;
        logic [4:0]         dh;
        logic [7:0]         colour;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [5:0] col_off(input logic [2:0] idx);
        logic [5:0] v;
        unique case (idx)
            3'd0: v = 6'd0;
            3'd1: v = 6'd1;
            3'd2: v = 6'd4;
            3'd3: v = 6'd5;
            3'd4: v = 6'd16;
            3'd5: v = 6'd17;
            3'd6: v = 6'd20;
            3'd7: v = 6'd21;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] row_off(input logic [2:0] idx);
        logic [5:0] v;
        unique case (idx)
            3'd0: v = 6'd0;
            3'd1: v = 6'd2;
            3'd2: v = 6'd8;
            3'd3: v = 6'd10;
            3'd4: v = 6'd32;
            3'd5: v = 6'd34;
            3'd6: v = 6'd40;
            3'd7: v = 6'd42;
        endcase
        return v;
    endfunction

    // log2 of grid width 1,2,1,2,4,2,4,8
    function automatic logic [1:0] grid_w_log(input logic [2:0] sel);
        logic [1:0] v;
        unique case (sel)
            3'd0, 3'd2:       v = 2'd0;
            3'd1, 3'd3, 3'd5: v = 2'd1;
            3'd4, 3'd6:       v = 2'd2;
            3'd7:             v = 2'd3;
        endcase
        return v;
    endfunction

    // log2 of grid height 1,1,2,2,2,4,4,8
    function automatic logic [1:0] grid_h_log(input logic [2:0] sel);
        logic [1:0] v;
        unique case (sel)
            3'd0, 3'd1:       v = 2'd0;
            3'd2, 3'd3, 3'd4: v = 2'd1;
            3'd5, 3'd6:       v = 2'd2;
            3'd7:             v = 2'd3;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* sv/sprite_tile_expander_top.sv */
// Top level of the sprite tile expander: config registers, front end, queue, sequencer.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  input    | i_valid / o_ready          | seven sprite attribute bytes
//  output   | o_valid / i_ready          | one tile: code, position, flips, size
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// For each sprite the sequencer first loads the job from the queue, then gives
// one tile beat per cycle while the output is not stalled, w x h beats in all.
// An accepted input beat passes through the queue and the job register before o_valid rises.
// The two-entry job queue takes input beats while the sequencer works; o_ready drops
// only when it is full. A stalled output beat holds the sequencer in place.
// Reset is synchronous, active low; config registers reset to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_tile_expander_top_assert.svh"
module sprite_tile_expander_top
    import ste_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_size_and_code_high,
    input  wire logic [7:0]         i_code_low,
    input  wire logic [7:0]         i_colour_byte,
    input  wire logic [7:0]         i_y_high_zoom_flip,
    input  wire logic [7:0]         i_y_low,
    input  wire logic [7:0]         i_x_high_zoom_flip,
    input  wire logic [7:0]         i_x_low,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [13:0]             o_tile_code,
    output logic signed [10:0]      o_tile_x,
    output logic signed [10:0]      o_tile_y,
    output logic                    o_mirror_x,
    output logic                    o_mirror_y,
    output logic [4:0]              o_drawn_width,
    output logic [4:0]              o_drawn_height,
    output logic [7:0]              o_tile_colour,
    output logic                    o_last_tile,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [13:0]        i_cfg_data
);

    logic        r_global_flip;
    logic [8:0]  r_crop_left;
    logic [8:0]  r_crop_top;
    logic [13:0] r_tile_code_mask;

    logic        push;
    logic        pop;
    logic        job_valid;
    t_job        push_job;
    t_job        head_job;
    t_q_status   q_status;
    logic        size_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_flip    <= 1'b0;
            r_crop_left      <= 9'd0;
            r_crop_top       <= 9'd0;
            r_tile_code_mask <= TILE_MASK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GLOBAL_FLIP: r_global_flip    <= i_cfg_data[0];
                CFG_CROP_LEFT:   r_crop_left      <= i_cfg_data[8:0];
                CFG_CROP_TOP:    r_crop_top       <= i_cfg_data[8:0];
                CFG_TILE_MASK:   r_tile_code_mask <= i_cfg_data;
            endcase
        end
    end

    ste_front u_front (
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_size_and_code_high (i_size_and_code_high),
        .i_code_low           (i_code_low),
        .i_colour_byte        (i_colour_byte),
        .i_y_high_zoom_flip   (i_y_high_zoom_flip),
        .i_y_low              (i_y_low),
        .i_x_high_zoom_flip   (i_x_high_zoom_flip),
        .i_x_low              (i_x_low),
        .i_global_flip        (r_global_flip),
        .i_q_full             (q_status.full),
        .o_push               (push),
        .o_job                (push_job)
    );

    ste_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_job),
        .i_pop    (pop),
        .o_valid  (job_valid),
        .o_data   (head_job),
        .o_status (q_status)
    );

    ste_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (job_valid),
        .i_job            (head_job),
        .o_pop            (pop),
        .i_crop_left      (r_crop_left),
        .i_crop_top       (r_crop_top),
        .i_tile_code_mask (r_tile_code_mask),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_tile_code      (o_tile_code),
        .o_tile_x         (o_tile_x),
        .o_tile_y         (o_tile_y),
        .o_mirror_x       (o_mirror_x),
        .o_mirror_y       (o_mirror_y),
        .o_drawn_width    (o_drawn_width),
        .o_drawn_height   (o_drawn_height),
        .o_tile_colour    (o_tile_colour),
        .o_last_tile      (o_last_tile)
    );

    assign size_ok = (o_drawn_width >= 5'd12) && (o_drawn_width <= 5'd16)
                     && (o_drawn_height >= 5'd12) && (o_drawn_height <= 5'd16);

    `STE_ASSERT_ALWAYS(a_q_state, !(q_status.full && q_status.empty), "queue full and empty")
    `STE_ASSERT_NEXT(a_beat_queued, i_valid && o_ready, !q_status.empty, "input beat lost")
    `STE_ASSERT_NEXT(a_size_range, 1'b1, !o_valid || size_ok, "tile size out of range")

endmodule
`default_nettype wire

/* sv/ste_front.sv */
// Front end: accepts attribute beats and decodes them into tile jobs.
`timescale 1ns / 1ps
`default_nettype none
module ste_front
    import ste_pkg::*;
(
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_size_and_code_high,
    input  wire logic [7:0] i_code_low,
    input  wire logic [7:0] i_colour_byte,
    input  wire logic [7:0] i_y_high_zoom_flip,
    input  wire logic [7:0] i_y_low,
    input  wire logic [7:0] i_x_high_zoom_flip,
    input  wire logic [7:0] i_x_low,
    input  wire logic       i_global_flip,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_job            o_job
);

    logic [2:0]         sel;
    logic [1:0]         wlog;
    logic [1:0]         hlog;
    logic [12:0]        clr;
    logic [5:0]         zx;
    logic [5:0]         zy;
    logic [8:0]         px;
    logic [8:0]         py;
    logic [11:0]        span_x;
    logic [11:0]        span_y;
    logic [9:0]         dw_raw;
    logic [9:0]         dh_raw;
    logic signed [11:0] ox0;
    logic signed [11:0] oy0;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        sel  = 3'((i_size_and_code_high & SIZE_MASK) >> 5);
        wlog = grid_w_log(sel);
        hlog = grid_h_log(sel);
        clr  = '1;
        clr[0] = !(wlog >= 2'd1);
        clr[1] = !(hlog >= 2'd1);
        clr[2] = !(wlog >= 2'd2);
        clr[3] = !(hlog >= 2'd2);
        clr[4] = !(wlog == 2'd3);
        clr[5] = !(hlog == 2'd3);

        zx = 6'((i_x_high_zoom_flip & ZOOM_MASK) >> 2);
        zy = 6'((i_y_high_zoom_flip & ZOOM_MASK) >> 2);
        px = ZOOM_ONE - {3'b0, zx};
        py = ZOOM_ONE - {3'b0, zy};

        span_x = 12'({3'b0, px} << wlog) + 12'd8;
        span_y = 12'({3'b0, py} << hlog) + 12'd8;
        dw_raw = {1'b0, px} + 10'd8;
        dh_raw = {1'b0, py} + 10'd8;

        ox0 = $signed({3'b0, i_x_high_zoom_flip[0], i_x_low});
        oy0 = 12'sd256 - $signed({3'b0, i_y_high_zoom_flip[0], i_y_low});

        o_job.base   = {i_size_and_code_high[4:0], i_code_low} & clr;
        o_job.px     = px;
        o_job.py     = py;
        o_job.w_log  = wlog;
        o_job.h_log  = hlog;
        o_job.dw     = (dw_raw[8:4] == 5'd0) ? 5'd1 : dw_raw[8:4];
        o_job.dh     = (dh_raw[8:4] == 5'd0) ? 5'd1 : dh_raw[8:4];
        o_job.colour = i_colour_byte;
        if (i_global_flip) begin
            o_job.ox = 12'sd512 - $signed({4'b0, span_x[11:4]}) - ox0;
            o_job.oy = 12'sd256 - $signed({4'b0, span_y[11:4]}) - oy0;
            o_job.fx = !i_x_high_zoom_flip[1];
            o_job.fy = !i_y_high_zoom_flip[1];
        end else begin
            o_job.ox = ox0;
            o_job.oy = oy0;
            o_job.fx = i_x_high_zoom_flip[1];
            o_job.fy = i_y_high_zoom_flip[1];
        end
    end

endmodule
`default_nettype wire

/* sv/ste_queue.sv */
// Two-entry job queue between front end and tile sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ste_queue
    import ste_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_data,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_data,
    output t_q_status o_status
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_valid        = !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* sv/ste_back.sv */
// Tile sequencer: walks the grid of one job and registers one tile per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module ste_back
    import ste_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    input  wire t_job               i_job,
    output logic                    o_pop,
    input  wire logic [8:0]         i_crop_left,
    input  wire logic [8:0]         i_crop_top,
    input  wire logic [13:0]        i_tile_code_mask,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [13:0]             o_tile_code,
    output logic signed [10:0]      o_tile_x,
    output logic signed [10:0]      o_tile_y,
    output logic                    o_mirror_x,
    output logic                    o_mirror_y,
    output logic [4:0]              o_drawn_width,
    output logic [4:0]              o_drawn_height,
    output logic [7:0]              o_tile_colour,
    output logic                    o_last_tile
);

    t_job               r_job;
    logic               r_busy;
    logic [2:0]         r_col;
    logic [2:0]         r_row;
    logic [10:0]        r_acc_x;
    logic [10:0]        r_acc_y;
    logic               r_out_valid;

    logic [2:0]         wm1;
    logic [2:0]         hm1;
    logic [2:0]         cidx;
    logic [2:0]         ridx;
    logic               emit;
    logic               last;
    logic [13:0]        n_code;
    logic signed [11:0] n_sx;
    logic signed [11:0] n_sy;

    always_comb begin
        wm1  = 3'((4'd1 << r_job.w_log) - 4'd1);
        hm1  = 3'((4'd1 << r_job.h_log) - 4'd1);
        cidx = r_job.fx ? (wm1 - r_col) : r_col;
        ridx = r_job.fy ? (hm1 - r_row) : r_row;
        last = (r_col == wm1) && (r_row == hm1);
        emit = r_busy && (!r_out_valid || i_ready);
        n_code = ({1'b0, r_job.base} + {8'b0, col_off(cidx)} + {8'b0, row_off(ridx)})
                 & i_tile_code_mask;
        n_sx = r_job.ox + $signed({5'b0, r_acc_x[10:4]}) - $signed({3'b0, i_crop_left});
        n_sy = r_job.oy + $signed({5'b0, r_acc_y[10:4]}) - $signed({3'b0, i_crop_top});
    end

    assign o_pop   = !r_busy && i_job_valid;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_col   <= 3'd0;
            r_row   <= 3'd0;
            r_acc_x <= 11'd8;
            r_acc_y <= 11'd8;
        end else if (emit && !last) begin
            if (r_col == wm1) begin
                r_col   <= 3'd0;
                r_acc_x <= 11'd8;
                r_row   <= r_row + 3'd1;
                r_acc_y <= r_acc_y + {2'b0, r_job.py};
            end else begin
                r_col   <= r_col + 3'd1;
                r_acc_x <= r_acc_x + {2'b0, r_job.px};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_tile_code    <= n_code;
            o_tile_x       <= n_sx[10:0];
            o_tile_y       <= n_sy[10:0];
            o_mirror_x     <= r_job.fx;
            o_mirror_y     <= r_job.fy;
            o_drawn_width  <= r_job.dw;
            o_drawn_height <= r_job.dh;
            o_tile_colour  <= r_job.colour;
            o_last_tile    <= last;
        end
    end

endmodule
`default_nettype wire

/* test/tb_sprite_tile_expander_top.sv */
// Testbench for sprite_tile_expander_top: checks every tile beat against a tile-grid predictor.
`timescale 1ns / 1ps
module tb_sprite_tile_expander_top;
    import ste_pkg::*;

    typedef struct packed {
        logic [7:0] size_code_hi;
        logic [7:0] code_lo;
        logic [7:0] colour;
        logic [7:0] y_hi;
        logic [7:0] y_lo;
        logic [7:0] x_hi;
        logic [7:0] x_lo;
    } t_sprite;

    typedef struct packed {
        logic [13:0]        code;
        logic signed [10:0] sx;
        logic signed [10:0] sy;
        logic               mx;
        logic               my;
        logic [4:0]         dw;
        logic [4:0]         dh;
        logic [7:0]         colour;
        logic               is_last;
    } t_tile;

    typedef enum logic {ROW_SPRITE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  cfg_idx;
        logic [13:0] cfg_data;
        t_sprite     spr;
        logic        typed;
        t_tile       want;
    } t_row;

    localparam t_sprite NO_SPRITE = '0;
    localparam t_tile   NO_TILE   = '0;

    localparam int COL_STEP   [8] = '{0, 1, 4, 5, 16, 17, 20, 21};
    localparam int ROW_STEP   [8] = '{0, 2, 8, 10, 32, 34, 40, 42};
    localparam int TILES_WIDE [8] = '{1, 2, 1, 2, 4, 2, 4, 8};
    localparam int TILES_TALL [8] = '{1, 1, 2, 2, 2, 4, 4, 8};

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 73;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIR       = 37;

    localparam t_row DIR_ROWS [N_DIR] = '{
        '{ROW_SPRITE, '0, '0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{14'h0000, 11'sd0, 11'sd256, 1'b0, 1'b0, 5'd16, 5'd16, 8'h00, 1'b1}},
        '{ROW_SPRITE, '0, '0, '{8'h1f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{14'h1fff, 11'sd511, -11'sd255, 1'b1, 1'b1, 5'd12, 5'd12, 8'hff, 1'b1}},
        '{ROW_SPRITE, '0, '0, '{8'h0a, 8'h55, 8'h10, 8'h01, 8'h00, 8'h00, 8'hff}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h3f, 8'hff, 8'h21, 8'h00, 8'h7f, 8'h01, 8'h00}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h5f, 8'hff, 8'h32, 8'h01, 8'hff, 8'h00, 8'h80}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h7f, 8'hff, 8'h43, 8'h00, 8'h01, 8'h01, 8'hfe}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h9f, 8'hff, 8'h54, 8'h01, 8'h10, 8'h00, 8'h08}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hbf, 8'hff, 8'h65, 8'h00, 8'hc0, 8'h01, 8'h3c}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hdf, 8'hff, 8'h76, 8'h01, 8'h33, 8'h00, 8'h99}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hff, 8'hff, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h12, 8'h34, 8'h98, 8'h82, 8'h40, 8'h7e, 8'h20}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h2c, 8'hc1, 8'ha9, 8'hfe, 8'h05, 8'h00, 8'hf0}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h45, 8'h0e, 8'hba, 8'h04, 8'hee, 8'h07, 8'h11}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h6e, 8'h77, 8'hcb, 8'h83, 8'h9a, 8'hfb, 8'h55}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h81, 8'h2a, 8'hdc, 8'h7e, 8'h01, 8'h82, 8'hcd}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'ha9, 8'hd5, 8'hed, 8'h02, 8'h80, 8'hfe, 8'h44}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hc3, 8'h6b, 8'hfe, 8'hfe, 8'hff, 8'h03, 8'h01}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hf7, 8'hb9, 8'h0f, 8'h03, 8'h66, 8'h7f, 8'h9e}, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_GLOBAL_FLIP, 14'h0001, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_CROP_LEFT,   14'h01ff, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_CROP_TOP,    14'h01ff, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_TILE_MASK,   14'h0000, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h00, 8'h00, 8'ha5, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{14'h0000, -11'sd15, -11'sd527, 1'b1, 1'b1, 5'd16, 5'd16, 8'ha5, 1'b1}},
        '{ROW_SPRITE, '0, '0, '{8'h1f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{14'h0000, -11'sd522, -11'sd12, 1'b0, 1'b0, 5'd12, 5'd12, 8'hff, 1'b1}},
        '{ROW_CFG, CFG_GLOBAL_FLIP, 14'h3ffe, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_CROP_LEFT,   14'h3e00, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_CROP_TOP,    14'h3e00, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_TILE_MASK,   14'h3fff, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{14'h0000, 11'sd0, 11'sd256, 1'b0, 1'b0, 5'd16, 5'd16, 8'h00, 1'b1}},
        '{ROW_CFG, CFG_GLOBAL_FLIP, 14'h3fff, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_CROP_LEFT,   14'h02a5, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_CROP_TOP,    14'h3d5a, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_CFG, CFG_TILE_MASK,   14'h1555, NO_SPRITE, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hf3, 8'h9c, 8'h3c, 8'h57, 8'h80, 8'hab, 8'h21}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'h8d, 8'h40, 8'h5a, 8'h00, 8'h00, 8'hfe, 8'hff}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hb0, 8'h0f, 8'hc3, 8'hfd, 8'h7c, 8'h02, 8'h10}, 1'b0, NO_TILE},
        '{ROW_SPRITE, '0, '0, '{8'hde, 8'he1, 8'h69, 8'h1b, 8'h2d, 8'h6d, 8'hb4}, 1'b0, NO_TILE}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_size_and_code_high;
    logic [7:0]         i_code_low;
    logic [7:0]         i_colour_byte;
    logic [7:0]         i_y_high_zoom_flip;
    logic [7:0]         i_y_low;
    logic [7:0]         i_x_high_zoom_flip;
    logic [7:0]         i_x_low;
    logic               o_valid;
    logic               i_ready;
    logic [13:0]        o_tile_code;
    logic signed [10:0] o_tile_x;
    logic signed [10:0] o_tile_y;
    logic               o_mirror_x;
    logic               o_mirror_y;
    logic [4:0]         o_drawn_width;
    logic [4:0]         o_drawn_height;
    logic [7:0]         o_tile_colour;
    logic               o_last_tile;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [13:0]        i_cfg_data;

    sprite_tile_expander_top dut (.*);

    // register copies for the tile predictor
    bit    scr_flip  = 1'b0;
    int    crop_x    = 0;
    int    crop_y    = 0;
    int    code_mask = 16383;

    t_tile pending_tiles [$];
    int    mismatches    = 0;
    int    tiles_seen    = 0;
    int    sprites_taken = 0;
    bit    calm_phase    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int zoom_span(input int zoom, input int k);
        return ((256 - zoom) * k + 8) >> 4;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic void expand_sprite(input t_sprite s);
        int    sel, wide, tall, base, ox, oy, ypos, zx, zy, dw, dh, sx, sy, ro, co;
        bit    fx, fy;
        t_tile t;
        sel  = s.size_code_hi[7:5];
        wide = TILES_WIDE[sel];
        tall = TILES_TALL[sel];
        base = {s.size_code_hi[4:0], s.code_lo};
        if (wide >= 2) base &= ~1;
        if (tall >= 2) base &= ~2;
        if (wide >= 4) base &= ~4;
        if (tall >= 4) base &= ~8;
        if (wide >= 8) base &= ~16;
        if (tall >= 8) base &= ~32;
        ox   = {s.x_hi[0], s.x_lo};
        ypos = {s.y_hi[0], s.y_lo};
        oy   = 256 - ypos;
        fx   = s.x_hi[1];
        fy   = s.y_hi[1];
        zx   = s.x_hi[7:2];
        zy   = s.y_hi[7:2];
        if (scr_flip) begin
            ox = 512 - zoom_span(zx, wide) - ox;
            oy = 256 - zoom_span(zy, tall) - oy;
            fx = !fx;
            fy = !fy;
        end
        dw = zoom_span(zx, 1);
        dh = zoom_span(zy, 1);
        if (dw < 1) dw = 1;
        if (dh < 1) dh = 1;
        for (int r = 0; r < tall; r++) begin
            sy = oy + zoom_span(zy, r) - crop_y;
            ro = fy ? ROW_STEP[tall - 1 - r] : ROW_STEP[r];
            for (int c = 0; c < wide; c++) begin
                sx = ox + zoom_span(zx, c) - crop_x;
                co = fx ? COL_STEP[wide - 1 - c] : COL_STEP[c];
                t.code    = 14'(((base + co + ro) & 'hffff) & code_mask);
                t.sx      = sx[10:0];
                t.sy      = sy[10:0];
                t.mx      = fx;
                t.my      = fy;
                t.dw      = dw[4:0];
                t.dh      = dh[4:0];
                t.colour  = s.colour;
                t.is_last = (r == tall - 1) && (c == wide - 1);
                pending_tiles.insert(pending_tiles.size(), t);
            end
        end
    endfunction

    function automatic t_sprite rand_sprite();
        t_sprite s;
        s.size_code_hi = 8'($urandom_range(0, 255));
        s.code_lo      = 8'($urandom_range(0, 255));
        s.colour       = 8'($urandom_range(0, 255));
        s.y_hi         = 8'($urandom_range(0, 255));
        s.y_lo         = 8'($urandom_range(0, 255));
        s.x_hi         = 8'($urandom_range(0, 255));
        s.x_lo         = 8'($urandom_range(0, 255));
        return s;
    endfunction

    function automatic int pick_level(input int top);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    // set junk in the bits above the register width half the time
    function automatic logic [13:0] widen(input int v, input int bits);
        int junk;
        junk = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16383);
        return 14'(((junk >> bits) << bits) | v);
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at tile %0d: %s got %0d, expected %0d", tiles_seen, what, got,
                     want);
    endtask

    // drop valid and hold until every pending tile has come out
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_tiles.size() != 0);
    endtask

    task automatic send_sprite(input t_sprite s, input logic typed, input t_tile want);
        int gap;
        i_valid              <= 1'b1;
        i_size_and_code_high <= s.size_code_hi;
        i_code_low           <= s.code_lo;
        i_colour_byte        <= s.colour;
        i_y_high_zoom_flip   <= s.y_hi;
        i_y_low              <= s.y_lo;
        i_x_high_zoom_flip   <= s.x_hi;
        i_x_low              <= s.x_lo;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sprites_taken++;
        if (typed) pending_tiles.insert(pending_tiles.size(), want);
        else expand_sprite(s);
        gap = (!calm_phase && $urandom_range(0, 9) < 3) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_GLOBAL_FLIP: scr_flip  = data[0];
            CFG_CROP_LEFT:   crop_x    = data[8:0];
            CFG_CROP_TOP:    crop_y    = data[8:0];
            CFG_TILE_MASK:   code_mask = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_registers(input int phase);
        int fl, cl, ct, mk;
        if (phase == 0) begin
            fl = 0; cl = 0; ct = 0; mk = 16383;
        end else if (phase == 1) begin
            fl = 1; cl = 511; ct = 511; mk = 16383;
        end else begin
            fl = pick_level(1);
            cl = pick_level(511);
            ct = pick_level(511);
            mk = pick_level(16383);
        end
        write_reg(CFG_GLOBAL_FLIP, widen(fl, 1));
        write_reg(CFG_CROP_LEFT, widen(cl, 9));
        write_reg(CFG_CROP_TOP, widen(ct, 9));
        write_reg(CFG_TILE_MASK, widen(mk, 14));
    endtask

    // output side: random stalls plus one long hold-off that backs the block up
    initial begin : sink_side
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sprites_taken >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm_phase && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_tile got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_tile_code, o_tile_x, o_tile_y, o_mirror_x, o_mirror_y,
                    o_drawn_width, o_drawn_height, o_tile_colour, o_last_tile};
            if (pending_tiles.size() == 0) begin
                note_mismatch("tile with nothing pending, code", got.code, -1);
            end else begin
                want = pending_tiles.pop_front();
                if (got.code !== want.code)     note_mismatch("tile_code", got.code, want.code);
                if (got.sx !== want.sx)         note_mismatch("tile_x", got.sx, want.sx);
                if (got.sy !== want.sy)         note_mismatch("tile_y", got.sy, want.sy);
                if (got.mx !== want.mx)         note_mismatch("mirror_x", got.mx, want.mx);
                if (got.my !== want.my)         note_mismatch("mirror_y", got.my, want.my);
                if (got.dw !== want.dw)         note_mismatch("drawn_width", got.dw, want.dw);
                if (got.dh !== want.dh)         note_mismatch("drawn_height", got.dh, want.dh);
                if (got.colour !== want.colour) note_mismatch("tile_colour", got.colour,
                                                              want.colour);
                if (got.is_last !== want.is_last) note_mismatch("last_tile", got.is_last,
                                                                want.is_last);
            end
            tiles_seen++;
        end
    end

    initial begin : stimulus
        i_rst_n              <= 1'b0;
        i_valid              <= 1'b0;
        i_size_and_code_high <= '0;
        i_code_low           <= '0;
        i_colour_byte        <= '0;
        i_y_high_zoom_flip   <= '0;
        i_y_low              <= '0;
        i_x_high_zoom_flip   <= '0;
        i_x_low              <= '0;
        i_cfg_valid          <= 1'b0;
        i_cfg_index          <= CFG_GLOBAL_FLIP;
        i_cfg_data           <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_reg(DIR_ROWS[i].cfg_idx, DIR_ROWS[i].cfg_data);
            else
                send_sprite(DIR_ROWS[i].spr, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_registers(p);
            calm_phase = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) drain();
                send_sprite(rand_sprite(), 1'b0, NO_TILE);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_tiles.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/ste_pkg.sv
sv/ste_front.sv
sv/ste_queue.sv
sv/ste_back.sv
sv/sprite_tile_expander_top.sv
test/tb_sprite_tile_expander_top.sv
